/* hdl/tlbc_pkg.sv */
// Shared types and constants of the masked ASID translation buffer.
package tlbc_pkg;

  localparam int IDX_W   = 4;
  localparam int ASID_W  = 8;
  localparam int FLAGS_W = 4;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic             wr_en;
    logic             flush;
    logic [IDX_W-1:0] index;
  } wr_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic             hit;
    op_e              op;
    logic [IDX_W-1:0] index;
  } tok_t;

endpackage

/* hdl/tlbc_cell.sv */
// One translation buffer slot that checks a passing search token and hands it on.
module tlbc_cell #(
  parameter int VPN_BITS = 21,
  parameter int PFN_BITS = 24,
  parameter int K        = 0,
  localparam int ENT_W   = 2 * VPN_BITS + tlbc_pkg::ASID_W + 1 + 2 * PFN_BITS + 2 +
                           2 * tlbc_pkg::FLAGS_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tlbc_pkg::wr_ctrl_t              ctrl_i,
  input  logic [ENT_W-1:0]                wr_entry_i,
  input  tlbc_pkg::tok_t                  tok_i,
  input  logic [VPN_BITS-1:0]             vpn_i,
  input  logic [tlbc_pkg::ASID_W-1:0]     asid_i,
  input  logic [ENT_W-1:0]                pay_i,
  output tlbc_pkg::tok_t                  tok_o,
  output logic [VPN_BITS-1:0]             vpn_o,
  output logic [tlbc_pkg::ASID_W-1:0]     asid_o,
  output logic [ENT_W-1:0]                pay_o
);
  import tlbc_pkg::*;

  localparam int FRM_W = 2 * PFN_BITS + 2 + 2 * FLAGS_W;

  logic [ENT_W-1:0]    entry_q, entry_d;
  logic                present_q, present_d;
  logic [VPN_BITS-1:0] e_vpn, e_mask;
  logic [ASID_W-1:0]   e_asid;
  logic                e_glob;
  logic                tag_eq, asid_ok, sel, take;
  tok_t                tok_q, tok_d;
  logic [VPN_BITS-1:0] vpn_q;
  logic [ASID_W-1:0]   asid_q;
  logic [ENT_W-1:0]    pay_q, pay_d;

  assign e_vpn  = entry_q[ENT_W-1 -: VPN_BITS];
  assign e_mask = entry_q[ENT_W-VPN_BITS-1 -: VPN_BITS];
  assign e_asid = entry_q[FRM_W+1 +: ASID_W];
  assign e_glob = entry_q[FRM_W];

  always_comb begin
    entry_d   = entry_q;
    present_d = present_q;
    if (ctrl_i.flush) begin
      entry_d   = '0;
      present_d = 1'b0;
    end else if (ctrl_i.wr_en && (32'(ctrl_i.index) == K)) begin
      entry_d   = wr_entry_i;
      present_d = 1'b1;
    end
  end

  always_comb begin
    tag_eq  = ((vpn_i ^ e_vpn) & ~e_mask) == '0;
    asid_ok = e_glob || (e_asid == asid_i);
    case (tok_i.op)
      OP_LOOKUP: sel = present_q && tag_eq && asid_ok;
      OP_READ:   sel = (32'(tok_i.index) == K);
      default:   sel = 1'b0;
    endcase
    take  = tok_i.valid && !tok_i.found && sel;
    tok_d = tok_i;
    pay_d = pay_i;
    if (take) begin
      tok_d.found = 1'b1;
      pay_d       = entry_q;
      if (tok_i.op == OP_LOOKUP) begin
        tok_d.hit   = 1'b1;
        tok_d.index = IDX_W'(K);
      end else begin
        tok_d.hit = present_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q   <= '0;
      present_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      entry_q   <= entry_d;
      present_q <= present_d;
      tok_q     <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vpn_q  <= vpn_i;
    asid_q <= asid_i;
    pay_q  <= pay_d;
  end

  assign tok_o  = tok_q;
  assign vpn_o  = vpn_q;
  assign asid_o = asid_q;
  assign pay_o  = pay_q;

endmodule

/* hdl/masked_asid_tlb_cam_top.sv */
// Top level of the masked ASID translation buffer built as a chain of slot cells.
// In lookup and read transactions a search token steps one cell a cycle along the chain.
// Write and flush results appear in the cycle after acceptance.
// One transaction is in flight at a time; a new one is accepted only after the last result is taken.
// Reset and flush clear every slot, its contents and its present bit at once.
module masked_asid_tlb_cam_top #(
  parameter int ENTRIES  = 16,
  parameter int VPN_BITS = 21,
  parameter int PFN_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [VPN_BITS-1:0]              vpn_i,
  input  logic [tlbc_pkg::ASID_W-1:0]      asid_i,
  input  logic [tlbc_pkg::IDX_W-1:0]       entry_index_i,
  input  logic [VPN_BITS-1:0]              page_mask_i,
  input  logic                             global_req_i,
  input  logic [PFN_BITS-1:0]              pfn_even_i,
  input  logic [PFN_BITS-1:0]              pfn_odd_i,
  input  logic                             valid_even_i,
  input  logic                             valid_odd_i,
  input  logic [tlbc_pkg::FLAGS_W-1:0]     flags_even_i,
  input  logic [tlbc_pkg::FLAGS_W-1:0]     flags_odd_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [tlbc_pkg::IDX_W-1:0]       match_index_o,
  output logic [VPN_BITS-1:0]              out_vpn_o,
  output logic [VPN_BITS-1:0]              out_mask_o,
  output logic [tlbc_pkg::ASID_W-1:0]      out_asid_o,
  output logic                             out_global_o,
  output logic [PFN_BITS-1:0]              out_pfn_even_o,
  output logic [PFN_BITS-1:0]              out_pfn_odd_o,
  output logic [1:0]                       out_valid_bits_o,
  output logic [tlbc_pkg::FLAGS_W-1:0]     out_flags_even_o,
  output logic [tlbc_pkg::FLAGS_W-1:0]     out_flags_odd_o
);
  import tlbc_pkg::*;

  localparam int FRM_W = 2 * PFN_BITS + 2 + 2 * FLAGS_W;
  localparam int ENT_W = 2 * VPN_BITS + ASID_W + 1 + FRM_W;

  state_e              state_q, state_d;
  op_e                 op;
  logic                accept;
  wr_ctrl_t            ctrl;
  logic [ENT_W-1:0]    wr_entry;
  tok_t                tok    [0:ENTRIES];
  logic [VPN_BITS-1:0] qvpn   [0:ENTRIES];
  logic [ASID_W-1:0]   qasid  [0:ENTRIES];
  logic [ENT_W-1:0]    pay    [0:ENTRIES];
  logic [ENTRIES-1:0]  tok_valids;
  logic                load;
  logic                res_hit_q, res_hit_d;
  logic [IDX_W-1:0]    res_idx_q, res_idx_d;
  logic [ENT_W-1:0]    res_ent_q, res_ent_d;

  assign op         = op_e'(op_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign wr_entry = {vpn_i, page_mask_i, asid_i, global_req_i, pfn_even_i, pfn_odd_i,
                     valid_odd_i, valid_even_i, flags_even_i, flags_odd_i};

  always_comb begin
    ctrl.wr_en   = accept && (op == OP_WRITE);
    ctrl.flush   = accept && (op == OP_FLUSH);
    ctrl.index   = entry_index_i;
    tok[0].valid = accept && (op == OP_LOOKUP || op == OP_READ);
    tok[0].found = 1'b0;
    tok[0].hit   = 1'b0;
    tok[0].op    = op;
    tok[0].index = (op == OP_READ) ? entry_index_i : '0;
  end

  assign qvpn[0]  = vpn_i;
  assign qasid[0] = asid_i;
  assign pay[0]   = '0;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    tlbc_cell #(
      .VPN_BITS(VPN_BITS),
      .PFN_BITS(PFN_BITS),
      .K       (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_entry_i(wr_entry),
      .tok_i     (tok[k]),
      .vpn_i     (qvpn[k]),
      .asid_i    (qasid[k]),
      .pay_i     (pay[k]),
      .tok_o     (tok[k+1]),
      .vpn_o     (qvpn[k+1]),
      .asid_o    (qasid[k+1]),
      .pay_o     (pay[k+1])
    );
    assign tok_valids[k] = tok[k+1].valid;
  end

  always_comb begin
    state_d   = state_q;
    load      = 1'b0;
    res_hit_d = tok[ENTRIES].hit;
    res_idx_d = tok[ENTRIES].index;
    res_ent_d = pay[ENTRIES];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_WRITE || op == OP_FLUSH) begin
            load      = 1'b1;
            res_hit_d = 1'b0;
            res_idx_d = '0;
            res_ent_d = '0;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_BUSY;
          end
        end
      end
      ST_BUSY: begin
        if (tok[ENTRIES].valid) begin
          load    = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_hit_q <= res_hit_d;
      res_idx_q <= res_idx_d;
      res_ent_q <= res_ent_d;
    end
  end

  assign out_valid_o      = (state_q == ST_DONE);
  assign hit_o            = res_hit_q;
  assign match_index_o    = res_idx_q;
  assign out_vpn_o        = res_ent_q[ENT_W-1 -: VPN_BITS];
  assign out_mask_o       = res_ent_q[ENT_W-VPN_BITS-1 -: VPN_BITS];
  assign out_asid_o       = res_ent_q[FRM_W+1 +: ASID_W];
  assign out_global_o     = res_ent_q[FRM_W];
  assign out_pfn_even_o   = res_ent_q[FRM_W-1 -: PFN_BITS];
  assign out_pfn_odd_o    = res_ent_q[FRM_W-PFN_BITS-1 -: PFN_BITS];
  assign out_valid_bits_o = res_ent_q[2*FLAGS_W +: 2];
  assign out_flags_even_o = res_ent_q[FLAGS_W +: FLAGS_W];
  assign out_flags_odd_o  = res_ent_q[0 +: FLAGS_W];

  // Only one search token may travel along the chain at any time.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valids))
    else $error("more than one search token in the chain");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valids != '0) |-> (state_q == ST_BUSY))
    else $error("search token outside a busy search");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_WRITE || op == OP_FLUSH)) |=> (out_valid_o && !hit_o))
    else $error("write or flush transaction did not complete in one cycle");

endmodule

/* verif/masked_asid_tlb_cam_top_tb.sv */
// Self-checking testbench of the masked ASID translation buffer top level.
`timescale 1ns / 1ps

module masked_asid_tlb_cam_top_tb;
  import tlbc_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int VPN_W       = 21;
  localparam int PFN_W       = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1600;
  localparam logic [VPN_W-1:0] VPN_MAX = {VPN_W{1'b1}};
  localparam logic [PFN_W-1:0] PFN_MAX = {PFN_W{1'b1}};

  typedef struct {
    op_e                op;
    logic [VPN_W-1:0]   vpn;
    logic [ASID_W-1:0]  asid;
    logic [IDX_W-1:0]   idx;
    logic [VPN_W-1:0]   mask;
    logic               glob;
    logic [PFN_W-1:0]   pfn_even;
    logic [PFN_W-1:0]   pfn_odd;
    logic               valid_even;
    logic               valid_odd;
    logic [FLAGS_W-1:0] flags_even;
    logic [FLAGS_W-1:0] flags_odd;
  } tlb_req_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [VPN_W-1:0]   vpn;
    logic [VPN_W-1:0]   mask;
    logic [ASID_W-1:0]  asid;
    logic               glob;
    logic [PFN_W-1:0]   pfn_even;
    logic [PFN_W-1:0]   pfn_odd;
    logic [1:0]         vbits;
    logic [FLAGS_W-1:0] flags_even;
    logic [FLAGS_W-1:0] flags_odd;
  } tlb_resp_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i             = '0;
  logic [VPN_W-1:0]   vpn_i            = '0;
  logic [ASID_W-1:0]  asid_i           = '0;
  logic [IDX_W-1:0]   entry_index_i    = '0;
  logic [VPN_W-1:0]   page_mask_i      = '0;
  logic               global_req_i     = 1'b0;
  logic [PFN_W-1:0]   pfn_even_i       = '0;
  logic [PFN_W-1:0]   pfn_odd_i        = '0;
  logic               valid_even_i     = 1'b0;
  logic               valid_odd_i      = 1'b0;
  logic [FLAGS_W-1:0] flags_even_i     = '0;
  logic [FLAGS_W-1:0] flags_odd_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic               hit_o;
  logic [IDX_W-1:0]   match_index_o;
  logic [VPN_W-1:0]   out_vpn_o;
  logic [VPN_W-1:0]   out_mask_o;
  logic [ASID_W-1:0]  out_asid_o;
  logic               out_global_o;
  logic [PFN_W-1:0]   out_pfn_even_o;
  logic [PFN_W-1:0]   out_pfn_odd_o;
  logic [1:0]         out_valid_bits_o;
  logic [FLAGS_W-1:0] out_flags_even_o;
  logic [FLAGS_W-1:0] out_flags_odd_o;

  tlb_resp_t        slot_entry [ENTRIES];
  logic             slot_present [ENTRIES];
  tlb_resp_t        expected_results [$];
  logic [VPN_W-1:0] vpn_pool [8];
  int unsigned      error_count   = 0;
  int unsigned      cycle_count   = 0;
  int unsigned      burst_left    = 0;
  bit               sender_gaps   = 1'b1;
  logic             hold_request  = 1'b0;
  int unsigned      hold_left     = 0;
  int unsigned      stall_mode    = 0;
  int unsigned      stall_mode_left = 0;

  masked_asid_tlb_cam_top #(
    .ENTRIES  (ENTRIES),
    .VPN_BITS (VPN_W),
    .PFN_BITS (PFN_W)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .vpn_i            (vpn_i),
    .asid_i           (asid_i),
    .entry_index_i    (entry_index_i),
    .page_mask_i      (page_mask_i),
    .global_req_i     (global_req_i),
    .pfn_even_i       (pfn_even_i),
    .pfn_odd_i        (pfn_odd_i),
    .valid_even_i     (valid_even_i),
    .valid_odd_i      (valid_odd_i),
    .flags_even_i     (flags_even_i),
    .flags_odd_i      (flags_odd_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .match_index_o    (match_index_o),
    .out_vpn_o        (out_vpn_o),
    .out_mask_o       (out_mask_o),
    .out_asid_o       (out_asid_o),
    .out_global_o     (out_global_o),
    .out_pfn_even_o   (out_pfn_even_o),
    .out_pfn_odd_o    (out_pfn_odd_o),
    .out_valid_bits_o (out_valid_bits_o),
    .out_flags_even_o (out_flags_even_o),
    .out_flags_odd_o  (out_flags_odd_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void clear_slots();
    for (int s = 0; s < ENTRIES; s++) begin
      slot_entry[s]   = '0;
      slot_present[s] = 1'b0;
    end
  endfunction

  function automatic tlb_resp_t translate_and_update(input tlb_req_t r);
    tlb_resp_t        res;
    logic [VPN_W-1:0] keep;
    res = '0;
    case (r.op)
      OP_LOOKUP: begin
        for (int s = 0; s < ENTRIES; s++) begin
          keep = ~slot_entry[s].mask;
          if (slot_present[s] && ((r.vpn & keep) == (slot_entry[s].vpn & keep)) &&
              (slot_entry[s].glob || slot_entry[s].asid == r.asid)) begin
            res     = slot_entry[s];
            res.hit = 1'b1;
            res.idx = IDX_W'(s);
            break;
          end
        end
      end
      OP_WRITE: begin
        if (int'(r.idx) < ENTRIES) begin
          slot_entry[r.idx] = '{hit: 1'b0, idx: '0, vpn: r.vpn, mask: r.mask, asid: r.asid,
                                glob: r.glob, pfn_even: r.pfn_even, pfn_odd: r.pfn_odd,
                                vbits: {r.valid_odd, r.valid_even},
                                flags_even: r.flags_even, flags_odd: r.flags_odd};
          slot_present[r.idx] = 1'b1;
        end
      end
      OP_FLUSH: begin
        clear_slots();
      end
      default: begin
        if (int'(r.idx) < ENTRIES) begin
          res     = slot_entry[r.idx];
          res.hit = slot_present[r.idx];
        end
        res.idx = r.idx;
      end
    endcase
    return res;
  endfunction

  function automatic tlb_req_t make_op(input op_e op, input logic [VPN_W-1:0] vpn,
                                       input logic [ASID_W-1:0] asid,
                                       input logic [IDX_W-1:0] idx);
    tlb_req_t r;
    r.op         = op;
    r.vpn        = vpn;
    r.asid       = asid;
    r.idx        = idx;
    r.mask       = VPN_W'($urandom_range(0, (1 << VPN_W) - 1));
    r.glob       = 1'($urandom_range(0, 1));
    r.pfn_even   = PFN_W'($urandom_range(0, (1 << PFN_W) - 1));
    r.pfn_odd    = PFN_W'($urandom_range(0, (1 << PFN_W) - 1));
    r.valid_even = 1'($urandom_range(0, 1));
    r.valid_odd  = 1'($urandom_range(0, 1));
    r.flags_even = FLAGS_W'($urandom_range(0, 15));
    r.flags_odd  = FLAGS_W'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic tlb_req_t make_write(input logic [IDX_W-1:0] idx,
                                          input logic [VPN_W-1:0] vpn,
                                          input logic [VPN_W-1:0] mask,
                                          input logic [ASID_W-1:0] asid, input logic glob,
                                          input logic [PFN_W-1:0] pfn_even,
                                          input logic [PFN_W-1:0] pfn_odd,
                                          input logic [1:0] vbits,
                                          input logic [FLAGS_W-1:0] flags_even,
                                          input logic [FLAGS_W-1:0] flags_odd);
    tlb_req_t r;
    r            = make_op(OP_WRITE, vpn, asid, idx);
    r.mask       = mask;
    r.glob       = glob;
    r.pfn_even   = pfn_even;
    r.pfn_odd    = pfn_odd;
    r.valid_even = vbits[0];
    r.valid_odd  = vbits[1];
    r.flags_even = flags_even;
    r.flags_odd  = flags_odd;
    return r;
  endfunction

  // Most lookups aim at a stored entry so that hits, near misses and priority are exercised.
  function automatic tlb_req_t random_request();
    tlb_req_t    r;
    int unsigned sel;
    int unsigned s;
    sel = $urandom_range(0, 99);
    r = make_op(OP_LOOKUP, VPN_W'($urandom_range(0, (1 << VPN_W) - 1)),
                ASID_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, ENTRIES - 1)));
    if ($urandom_range(0, 4) == 0) r.asid = ASID_W'($urandom_range(0, 255));
    if (sel < 3) begin
      r.op = OP_FLUSH;
    end else if (sel < 30) begin
      r.op = OP_WRITE;
      if ($urandom_range(0, 9) < 6) r.vpn = vpn_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: r.mask = '0;
        5, 6, 7:       r.mask = VPN_MAX >> $urandom_range(VPN_W - 12, VPN_W - 1);
        default:       r.mask = VPN_W'($urandom_range(0, (1 << VPN_W) - 1));
      endcase
      r.glob = ($urandom_range(0, 3) == 0);
    end else if (sel < 48) begin
      r.op = OP_READ;
    end else if ($urandom_range(0, 99) < 65) begin
      s = $urandom_range(0, ENTRIES - 1);
      if (slot_present[s]) begin
        r.vpn = slot_entry[s].vpn ^
                (VPN_W'($urandom_range(0, (1 << VPN_W) - 1)) & slot_entry[s].mask);
        if ($urandom_range(0, 9) < 8) r.asid = slot_entry[s].asid;
        if ($urandom_range(0, 6) == 0) r.vpn[$urandom_range(0, VPN_W - 1)] ^= 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_item(input tlb_req_t r);
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i    <= 1'b1;
    op_i          <= r.op;
    vpn_i         <= r.vpn;
    asid_i        <= r.asid;
    entry_index_i <= r.idx;
    page_mask_i   <= r.mask;
    global_req_i  <= r.glob;
    pfn_even_i    <= r.pfn_even;
    pfn_odd_i     <= r.pfn_odd;
    valid_even_i  <= r.valid_even;
    valid_odd_i   <= r.valid_odd;
    flags_even_i  <= r.flags_even;
    flags_odd_i   <= r.flags_odd;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(translate_and_update(r));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic test_empty_table();
    send_item(make_op(OP_READ, VPN_MAX, 8'hFF, 4'd0));
    send_item(make_op(OP_READ, '0, '0, 4'd15));
    send_item(make_op(OP_LOOKUP, '0, '0, 4'd0));
    send_item(make_op(OP_LOOKUP, VPN_MAX, 8'hFF, 4'd15));
  endtask

  task automatic test_field_extremes();
    send_item(make_write(4'd0, VPN_MAX, '0, 8'hFF, 1'b0, PFN_MAX, PFN_MAX, 2'b11,
                         4'hF, 4'hF));
    send_item(make_write(4'd15, '0, VPN_MAX, 8'h00, 1'b1, '0, '0, 2'b00, 4'h0, 4'h0));
    send_item(make_op(OP_READ, '0, '0, 4'd0));
    send_item(make_op(OP_READ, '0, '0, 4'd15));
    send_item(make_op(OP_LOOKUP, VPN_MAX, 8'hFF, 4'd0));
    send_item(make_op(OP_LOOKUP, VPN_MAX, 8'h00, 4'd0));
  endtask

  // A present entry with both valid bits clear still takes part in lookups.
  task automatic test_lowest_index_wins();
    send_item(make_write(4'd3, '0, '0, 8'h07, 1'b0, 24'h123456, 24'h654321, 2'b00,
                         4'h5, 4'hA));
    send_item(make_write(4'd9, '0, '0, 8'h07, 1'b1, 24'hABCDEF, 24'h0F0F0F, 2'b10,
                         4'h3, 4'hC));
    send_item(make_op(OP_LOOKUP, '0, 8'h07, 4'd0));
    send_item(make_op(OP_LOOKUP, '0, 8'h08, 4'd0));
  endtask

  task automatic test_partial_mask();
    send_item(make_write(4'd5, 21'h12345, 21'h000FF, 8'h42, 1'b0, 24'h000001, 24'h800000,
                         2'b01, 4'h9, 4'h6));
    send_item(make_op(OP_LOOKUP, 21'h123AB, 8'h42, 4'd0));
    send_item(make_op(OP_LOOKUP, 21'h12445, 8'h42, 4'd0));
  endtask

  task automatic test_flush();
    send_item(make_op(OP_FLUSH, VPN_MAX, 8'hFF, 4'd15));
    send_item(make_op(OP_LOOKUP, VPN_MAX, 8'hFF, 4'd0));
    send_item(make_op(OP_READ, '0, '0, 4'd15));
  endtask

  task automatic test_random_traffic();
    repeat (RANDOM_ITEMS) send_item(random_request());
  endtask

  // The receiver holds off while the sender keeps offering, so the input must stall.
  task automatic test_output_backpressure();
    drain_results();
    sender_gaps  = 1'b0;
    hold_request <= 1'b1;
    repeat (12) send_item(random_request());
    sender_gaps  = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    repeat (40) send_item(random_request());
    drain_results();
    repeat (40) send_item(random_request());
  endtask

  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode      <= $urandom_range(0, 3);
      stall_mode_left <= $urandom_range(32, 256);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      out_stall_i  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_stall_i  <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= (stall_mode_left % 5 < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    tlb_resp_t got;
    tlb_resp_t want;
    bit        bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{hit: hit_o, idx: match_index_o, vpn: out_vpn_o, mask: out_mask_o,
              asid: out_asid_o, glob: out_global_o, pfn_even: out_pfn_even_o,
              pfn_odd: out_pfn_odd_o, vbits: out_valid_bits_o,
              flags_even: out_flags_even_o, flags_odd: out_flags_odd_o};
      if (expected_results.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < 10)
          $display("Unexpected transaction: hit=%0d idx=%0d vpn=%h", got.hit, got.idx,
                   got.vpn);
      end else begin
        want = expected_results.pop_front();
        bad  = (got.hit !== want.hit) || (got.idx !== want.idx) ||
               (got.vpn !== want.vpn) || (got.mask !== want.mask) ||
               (got.asid !== want.asid) || (got.glob !== want.glob) ||
               (got.pfn_even !== want.pfn_even) || (got.pfn_odd !== want.pfn_odd) ||
               (got.vbits !== want.vbits) || (got.flags_even !== want.flags_even) ||
               (got.flags_odd !== want.flags_odd);
        if (bad) begin
          error_count <= error_count + 1;
          if (error_count < 10) begin
            $display("Mismatch exp: hit=%0d idx=%0d vpn=%h mask=%h asid=%h g=%0d ",
                     want.hit, want.idx, want.vpn, want.mask, want.asid, want.glob,
                     "pe=%h po=%h v=%b fe=%h fo=%h",
                     want.pfn_even, want.pfn_odd, want.vbits, want.flags_even,
                     want.flags_odd);
            $display("Mismatch got: hit=%0d idx=%0d vpn=%h mask=%h asid=%h g=%0d ",
                     got.hit, got.idx, got.vpn, got.mask, got.asid, got.glob,
                     "pe=%h po=%h v=%b fe=%h fo=%h",
                     got.pfn_even, got.pfn_odd, got.vbits, got.flags_even,
                     got.flags_odd);
          end
        end
      end
    end
  end

  initial begin
    clear_slots();
    for (int p = 0; p < 8; p++) vpn_pool[p] = VPN_W'($urandom_range(0, (1 << VPN_W) - 1));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_field_extremes();
    test_lowest_index_wins();
    test_partial_mask();
    test_flush();
    test_output_backpressure();
    test_random_traffic();
    test_pause_until_drained();
    drain_results();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
